>>> src/wfd_pkg.sv
// Shared types, sizes and codes for the wait-for deadlock detector.
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int MAX_EDGES = 64;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int STEP_W    = $clog2(MAX_EDGES + 2);
    localparam int ID_W      = 64;
    localparam int OUT_CNT_W = 7;

    localparam logic [1:0] OP_NOTE       = 2'd0;
    localparam logic [1:0] OP_CLEAR      = 2'd1;
    localparam logic [1:0] OP_CLEAR_PAIR = 2'd2;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] waiter_id;
        logic [ID_W-1:0] holder_id;
    } in_t;

    typedef struct packed {
        logic                 deadlock;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] edges_removed;
        logic [OUT_CNT_W-1:0] edge_count;
    } out_t;

    typedef enum logic [1:0] {
        SCAN_AT     = 2'd0,
        SCAN_WAITER = 2'd1,
        SCAN_CLEAR  = 2'd2,
        SCAN_PAIR   = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       set_dead;
        logic       update;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_over;
        logic walk_self;
        logic scan_done;
        logic scan_hit;
    } stat_t;

endpackage

>>> src/wfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/wfd_datapath.sv
// Edge table, scan engine, chain walk registers and result register.
`timescale 1ns / 1ps

module wfd_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  wfd_pkg::in_t  s_data,
    input  wfd_pkg::cmd_t cmd,
    output wfd_pkg::stat_t stat,
    output wfd_pkg::out_t m_data
);

    localparam logic [wfd_pkg::IDX_W-1:0] LAST_IDX = wfd_pkg::IDX_W'(wfd_pkg::MAX_EDGES - 1);

    logic [wfd_pkg::ID_W-1:0]      waiter_reg, holder_reg, at_reg;
    logic [wfd_pkg::ID_W-1:0]      at_next;
    logic [wfd_pkg::STEP_W-1:0]    steps_reg, steps_next;
    logic [wfd_pkg::MAX_EDGES-1:0] valid_reg, valid_next;
    logic [wfd_pkg::CNT_W-1:0]     total_reg, total_next;
    logic [wfd_pkg::CNT_W-1:0]     removed_reg, removed_next;
    logic                          dead_reg, dead_next;
    logic                          full_reg, full_next;
    logic                          find_hit_reg, find_hit_next;
    logic [wfd_pkg::IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                          free_found_reg, free_found_next;
    logic [wfd_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    wfd_pkg::scan_mode_t           mode_reg, mode_next;
    logic                          run_reg, run_next;
    logic [wfd_pkg::IDX_W-1:0]     addr_reg, addr_next;
    logic                          pend_reg, pend_next;
    logic [wfd_pkg::IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    wfd_pkg::out_t                 out_reg;

    logic [wfd_pkg::ID_W-1:0]  rd_waiter, rd_holder, key;
    logic                      rd_valid, match, hit, stop;
    logic                      we_waiter, we_holder;
    logic [wfd_pkg::IDX_W-1:0] waddr;

    wfd_ram #(.WIDTH(wfd_pkg::ID_W), .DEPTH(wfd_pkg::MAX_EDGES)) u_waiter_ram (
        .aclk  (aclk),
        .we    (we_waiter),
        .waddr (waddr),
        .wdata (waiter_reg),
        .raddr (addr_reg),
        .rdata (rd_waiter)
    );

    wfd_ram #(.WIDTH(wfd_pkg::ID_W), .DEPTH(wfd_pkg::MAX_EDGES)) u_holder_ram (
        .aclk  (aclk),
        .we    (we_holder),
        .waddr (waddr),
        .wdata (holder_reg),
        .raddr (addr_reg),
        .rdata (rd_holder)
    );

    // Compare stage of the scan
    always_comb begin
        key      = (mode_reg == wfd_pkg::SCAN_AT) ? at_reg : waiter_reg;
        rd_valid = valid_reg[rd_idx_reg];
        match    = rd_valid && (rd_waiter == key) &&
                   ((mode_reg != wfd_pkg::SCAN_PAIR) || (rd_holder == holder_reg));
        hit      = pend_reg && match;
        stop     = hit && ((mode_reg == wfd_pkg::SCAN_AT) || (mode_reg == wfd_pkg::SCAN_WAITER));
    end

    assign stat.walk_over = steps_reg > wfd_pkg::STEP_W'(total_reg);
    assign stat.walk_self = at_reg == waiter_reg;
    assign stat.scan_done = pend_reg && (stop || (rd_idx_reg == LAST_IDX));
    assign stat.scan_hit  = hit;

    // Table write: retarget an existing edge or append in the first free slot
    assign we_holder = cmd.update && (find_hit_reg || free_found_reg);
    assign we_waiter = cmd.update && !find_hit_reg && free_found_reg;
    assign waddr     = find_hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb begin
        at_next         = at_reg;
        steps_next      = steps_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        removed_next    = removed_reg;
        dead_next       = dead_reg;
        full_next       = full_reg;
        find_hit_next   = find_hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        mode_next       = mode_reg;
        run_next        = run_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;

        // Issue stage
        if (run_reg) begin
            pend_next   = 1'b1;
            rd_idx_next = addr_reg;
            addr_next   = addr_reg + 1'b1;
            if (addr_reg == LAST_IDX) begin
                run_next = 1'b0;
            end
        end
        if (stop) begin
            run_next  = 1'b0;
            pend_next = 1'b0;
        end

        if (hit) begin
            unique case (mode_reg)
                wfd_pkg::SCAN_AT: begin
                    at_next    = rd_holder;
                    steps_next = steps_reg + 1'b1;
                end
                wfd_pkg::SCAN_WAITER: begin
                    find_hit_next = 1'b1;
                    hit_idx_next  = rd_idx_reg;
                end
                wfd_pkg::SCAN_CLEAR, wfd_pkg::SCAN_PAIR: begin
                    valid_next[rd_idx_reg] = 1'b0;
                    removed_next           = removed_reg + 1'b1;
                    total_next             = total_reg - 1'b1;
                end
            endcase
        end

        // Remember the lowest free slot while searching for the waiter
        if (pend_reg && (mode_reg == wfd_pkg::SCAN_WAITER) && !rd_valid && !free_found_reg) begin
            free_found_next = 1'b1;
            free_idx_next   = rd_idx_reg;
        end

        if (cmd.update) begin
            if (!find_hit_reg) begin
                if (free_found_reg) begin
                    valid_next[free_idx_reg] = 1'b1;
                    total_next               = total_reg + 1'b1;
                end else begin
                    full_next = 1'b1;
                end
            end
        end

        if (cmd.set_dead) begin
            dead_next = 1'b1;
        end

        if (cmd.scan_start) begin
            mode_next       = cmd.scan_mode;
            run_next        = 1'b1;
            addr_next       = '0;
            pend_next       = 1'b0;
            find_hit_next   = 1'b0;
            free_found_next = 1'b0;
        end

        if (cmd.load) begin
            at_next      = s_data.holder_id;
            steps_next   = '0;
            removed_next = '0;
            dead_next    = 1'b0;
            full_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            total_reg <= '0;
            run_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            total_reg <= total_next;
            run_reg   <= run_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            waiter_reg <= s_data.waiter_id;
            holder_reg <= s_data.holder_id;
        end
        at_reg         <= at_next;
        steps_reg      <= steps_next;
        removed_reg    <= removed_next;
        dead_reg       <= dead_next;
        full_reg       <= full_next;
        find_hit_reg   <= find_hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        if (cmd.out_load) begin
            out_reg.deadlock      <= dead_reg;
            out_reg.table_full    <= full_reg;
            out_reg.edges_removed <= wfd_pkg::OUT_CNT_W'(removed_reg);
            out_reg.edge_count    <= wfd_pkg::OUT_CNT_W'(total_reg);
        end
    end

    assign m_data = out_reg;

endmodule

>>> src/wfd_ctrl.sv
// Operation sequencer: chain walk, waiter search, table update, clears, handshakes.
`timescale 1ns / 1ps

module wfd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_opcode,
    output logic           m_valid,
    input  logic           m_ready,
    input  wfd_pkg::stat_t stat,
    output wfd_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_WALK_CHECK = 7'b0000010,
        ST_WALK_SCAN  = 7'b0000100,
        ST_FIND       = 7'b0001000,
        ST_UPDATE     = 7'b0010000,
        ST_CLEAR      = 7'b0100000,
        ST_DONE       = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == ST_IDLE;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    priority if (s_opcode == wfd_pkg::OP_NOTE) begin
                        state_next = ST_WALK_CHECK;
                    end else if (s_opcode == wfd_pkg::OP_CLEAR) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = wfd_pkg::SCAN_CLEAR;
                        state_next     = ST_CLEAR;
                    end else if (s_opcode == wfd_pkg::OP_CLEAR_PAIR) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = wfd_pkg::SCAN_PAIR;
                        state_next     = ST_CLEAR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK_CHECK: begin
                priority if (stat.walk_over) begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = wfd_pkg::SCAN_WAITER;
                    state_next     = ST_FIND;
                end else if (stat.walk_self) begin
                    cmd.set_dead = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = wfd_pkg::SCAN_AT;
                    state_next     = ST_WALK_SCAN;
                end
            end
            ST_WALK_SCAN: begin
                if (stat.scan_done) begin
                    if (stat.scan_hit) begin
                        state_next = ST_WALK_CHECK;
                    end else begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = wfd_pkg::SCAN_WAITER;
                        state_next     = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                if (stat.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> src/wait_for_deadlock_detector.sv
// Top level of the wait-for deadlock detector.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one operation per transfer:
//   note a wait edge (waiter waits for holder), clear by waiter, or clear by
//   waiter and holder. Result channel m_valid/m_ready/m_data returns exactly
//   one result per operation: deadlock, table_full, edges_removed, edge_count.
//   Edges live in two 64-entry RAMs (waiter, holder) with valid flags in
//   flip-flops. Every table lookup is a linear scan through the RAM read port,
//   one entry per cycle. Walk and waiter scans stop at the first matching
//   edge; clear scans visit every entry and drop each match.
// Sequence of an operation, with T = edges held: clear is one scan; an
//   unused opcode runs no scan. note: a chain walk of at most T + 1 steps,
//   each a scan, then, unless the walk reaches the waiter (deadlock), a
//   waiter search scan and a table update.
//   One operation is in flight at a time; s_ready rises again as soon as the
//   result moves into the output register.
// Reset (aresetn low, synchronous) empties the table at once: valid flags and
//   edge count clear, no sweep is needed. A stalled receiver holds the result
//   in the output register; the next operation may be accepted and run, and
//   its result waits until the output register frees up.

module wait_for_deadlock_detector (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wfd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output wfd_pkg::out_t m_data
);

    wfd_pkg::cmd_t  cmd;
    wfd_pkg::stat_t stat;

    // Sequencer: owns the handshakes and steps each operation through its scans
    wfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_data.opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: edge table, scan engine, walk position and result register
    wfd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

>>> src/wfd_checker.sv
// Port-level checker for the wait-for deadlock detector, bound to the top level.
`timescale 1ns / 1ps

module wfd_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input wfd_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input wfd_pkg::out_t m_data
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Never flag deadlock and full table together
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.deadlock && m_data.table_full))
        else $error("deadlock and table_full both set");

    // A refused note removes nothing
    a_note_no_removal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.deadlock || m_data.table_full) |-> m_data.edges_removed == '0)
        else $error("edges_removed nonzero on a refused note");

    // A full refusal reports a full table
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |->
            m_data.edge_count == wfd_pkg::OUT_CNT_W'(wfd_pkg::MAX_EDGES))
        else $error("table_full with edge_count below capacity");

    // Drop any result out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind wait_for_deadlock_detector wfd_checker u_wfd_checker (.*);
